[design/srisc_pkg.sv]
// Package for the sixteen-bit RISC core step block: item kinds, opcodes,
// function codes, sequencer states and the shared payload structs.
// No dependencies.
`default_nettype none

package srisc_pkg;

  localparam int ADDR_W = 13;
  localparam int WORD_W = 16;
  localparam int RIDX_W = 3;

  // item kinds (s_tuser)
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // instruction opcodes, word bits 15:13
  localparam logic [2:0] OPC_ALU  = 3'd0;
  localparam logic [2:0] OPC_ADDI = 3'd1;
  localparam logic [2:0] OPC_J    = 3'd2;
  localparam logic [2:0] OPC_JAL  = 3'd3;
  localparam logic [2:0] OPC_LW   = 3'd4;
  localparam logic [2:0] OPC_SW   = 3'd5;
  localparam logic [2:0] OPC_JEQ  = 3'd6;
  localparam logic [2:0] OPC_SLTI = 3'd7;

  // function codes for the register-register group
  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_AND = 4'd2;
  localparam logic [3:0] FN_OR  = 4'd3;
  localparam logic [3:0] FN_SLT = 4'd4;
  localparam logic [3:0] FN_JR  = 4'd8;

  localparam logic [RIDX_W-1:0] LINK_REG = 3'd7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_READ,
    ST_DECODE,
    ST_EXEC,
    ST_LWB,
    ST_DONE
  } state_t;

  // register file write port
  typedef struct packed {
    logic              we;
    logic [RIDX_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } rf_wr_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] mem_data;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_written;
    logic [WORD_W-1:0] reg_value;
    logic [RIDX_W-1:0] reg_index;
    logic              reg_written;
    logic              halted;
    logic [ADDR_W-1:0] pc_now;
  } res_t;

endpackage

`default_nettype wire

[design/sixteen_bit_risc_core_step.sv]
// Sixteen-bit RISC core, stepped one item at a time over a shared word memory.
// Input transaction: s_tuser = item kind (load word, execute, read word),
// s_tdata = load_addr, load_data. One result transaction per input item on
// the m_ side: pc, halt flag, register write, memory store and read data.
// One item is in flight at a time; the next one is taken while a finished
// result still waits in the output register.
// Accept to result (receiver ready): a load ends in ISSUE, a read passes ISSUE
// and READ, an execute ISSUE, DECODE and EXEC, and an lw adds LWB. The main
// memory has one port, so instruction fetch, register read and the lw/sw data
// access each take their own step. A stalled receiver adds the stall time;
// the result is held in m_tdata. After rst the main memory is swept to zero,
// one word a cycle, over all MEM_WORDS (8192) words; s_tready stays low during
// that pass. The register file, pc and halt flag clear at once. A jump to its
// own address halts the core: later execute items report the frozen state.
`default_nettype none

module sixteen_bit_risc_core_step #(
  parameter int MEM_WORDS = 8192,
  parameter int REG_COUNT = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,  // load_addr[12:0], load_data[28:13], zero pad
  input  wire  [1:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  wire         m_tready,
  // pc_now[12:0], halted[13], reg_written[14], reg_index[17:15],
  // reg_value[33:18], mem_written[34], mem_addr[47:35], mem_data[63:48],
  // read_data[79:64]
  output logic [79:0] m_tdata
);
  import srisc_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  state_t state, state_next;

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] mem_q;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  logic [AW-1:0]     clr_cnt;
  logic [1:0]        in_op;
  logic [ADDR_W-1:0] in_addr;
  logic [WORD_W-1:0] in_data;
  logic [WORD_W-1:0] ir;
  logic [RIDX_W-1:0] lw_dst;
  logic [ADDR_W-1:0] pc, pc_next;
  logic              halt, halt_next;

  logic              out_valid;
  res_t              out_q;
  res_t              res;
  res_t              res_next;
  logic              finish;
  logic              out_free;
  logic              out_push;

  logic [RIDX_W-1:0] rf_ra, rf_rb;
  logic [WORD_W-1:0] rf_a, rf_b;
  rf_wr_t            rf_wr;

  // instruction fields
  logic [2:0]        opc;
  logic [3:0]        fn;
  logic [WORD_W-1:0] imm;
  logic [ADDR_W-1:0] target;
  logic [ADDR_W-1:0] eff;
  logic [WORD_W-1:0] alu_val;
  logic              alu_wr;
  logic [RIDX_W-1:0] alu_dst;

  srisc_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .ra_addr(rf_ra),
    .rb_addr(rf_rb),
    .ra_data(rf_a),
    .rb_data(rf_b),
    .wr     (rf_wr)
  );

  // main memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  assign opc    = ir[15:13];
  assign fn     = ir[3:0];
  assign imm    = {{(WORD_W-7){ir[6]}}, ir[6:0]};
  assign target = ir[ADDR_W-1:0];
  assign eff    = ADDR_W'(rf_a + imm);
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;
    rf_ra      = mem_q[12:10];
    rf_rb      = mem_q[9:7];
    rf_wr      = '0;
    pc_next    = pc;
    halt_next  = halt;
    finish     = 1'b0;
    alu_val    = '0;
    alu_wr     = 1'b0;
    alu_dst    = '0;
    res_next   = '0;

    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        if (clr_cnt == AW'(MEM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (in_op)
          OP_LOAD: begin
            mem_we    = 1'b1;
            mem_addr  = in_addr[AW-1:0];
            mem_wdata = in_data;
            finish    = 1'b1;
          end
          OP_READ: begin
            mem_addr   = in_addr[AW-1:0];
            state_next = ST_READ;
          end
          OP_EXEC: begin
            if (halt) begin
              finish = 1'b1;
            end else begin
              mem_addr   = pc[AW-1:0];
              state_next = ST_DECODE;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      ST_READ: begin
        res_next.read_data = mem_q;
        finish = 1'b1;
      end
      ST_DECODE: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        pc_next = pc + 1'b1;
        finish  = 1'b1;
        case (opc)
          OPC_ALU: begin
            alu_dst = ir[6:4];
            alu_wr  = 1'b1;
            case (fn)
              FN_ADD: alu_val = rf_a + rf_b;
              FN_SUB: alu_val = rf_a - rf_b;
              FN_AND: alu_val = rf_a & rf_b;
              FN_OR:  alu_val = rf_a | rf_b;
              FN_SLT: alu_val = {{(WORD_W-1){1'b0}}, rf_a < rf_b};
              FN_JR: begin
                alu_wr  = 1'b0;
                pc_next = rf_a[ADDR_W-1:0];
              end
              default: alu_wr = 1'b0;
            endcase
          end
          OPC_ADDI: begin
            alu_dst = ir[9:7];
            alu_wr  = 1'b1;
            alu_val = rf_a + imm;
          end
          OPC_SLTI: begin
            alu_dst = ir[9:7];
            alu_wr  = 1'b1;
            alu_val = {{(WORD_W-1){1'b0}}, rf_a < imm};
          end
          OPC_LW: begin
            mem_addr   = eff[AW-1:0];
            finish     = 1'b0;
            state_next = ST_LWB;
          end
          OPC_SW: begin
            mem_we    = 1'b1;
            mem_addr  = eff[AW-1:0];
            mem_wdata = rf_b;
            res_next.mem_written = 1'b1;
            res_next.mem_addr    = eff;
            res_next.mem_data    = rf_b;
          end
          OPC_JEQ: begin
            if (rf_a == rf_b) begin
              pc_next = pc + 1'b1 + imm[ADDR_W-1:0];
            end
          end
          OPC_J: begin
            if (target == pc) begin
              halt_next = 1'b1;
              pc_next   = pc;
            end else begin
              pc_next = target;
            end
          end
          OPC_JAL: begin
            alu_dst = LINK_REG;
            alu_wr  = 1'b1;
            alu_val = WORD_W'(pc) + 1'b1;
            pc_next = target;
          end
          default: alu_wr = 1'b0;
        endcase
        if (alu_wr && alu_dst != '0) begin
          rf_wr.we   = 1'b1;
          rf_wr.addr = alu_dst;
          rf_wr.data = alu_val;
          res_next.reg_written = 1'b1;
          res_next.reg_index   = alu_dst;
          res_next.reg_value   = alu_val;
        end
      end
      ST_LWB: begin
        finish = 1'b1;
        if (lw_dst != '0) begin
          rf_wr.we   = 1'b1;
          rf_wr.addr = lw_dst;
          rf_wr.data = mem_q;
          res_next.reg_written = 1'b1;
          res_next.reg_index   = lw_dst;
          res_next.reg_value   = mem_q;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    res_next.pc_now = pc_next;
    res_next.halted = halt_next;

    if (finish) begin
      state_next = out_free ? ST_IDLE : ST_DONE;
    end
  end

  assign out_push = out_free && (finish || state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pc        <= '0;
      halt      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pc      <= pc_next;
      halt    <= halt_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_addr <= s_tdata[12:0];
      in_data <= s_tdata[28:13];
    end
    if (state == ST_DECODE) begin
      ir <= mem_q;
    end
    if (state == ST_EXEC) begin
      lw_dst <= ir[9:7];
    end
    if (finish) begin
      res <= res_next;
    end
    if (out_push) begin
      out_q <= (state == ST_DONE) ? res : res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

`ifndef SYNTHESIS
  // register 0 is never reported as written
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[14] && m_tdata[17:15] == 3'd0))
    else $error("result reports a write to register 0");

  // halt is sticky and freezes the pc
  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt && $stable(pc))
    else $error("pc or halt changed after halt");

  // no item taken during the memory clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("input ready during memory clear");

  // a result is only produced for an item that was accepted
  a_push_after_item: assert property (@(posedge clk) disable iff (rst)
    out_push && state != ST_DONE |-> state != ST_IDLE && state != ST_CLEAR)
    else $error("result pushed without an item in flight");
`endif

endmodule

`default_nettype wire

[design/srisc_regfile.sv]
// Register file of the RISC core step block: two registered read ports,
// one write port, per-entry valid bits so that reset reads as zero.
// Depends on srisc_pkg.
`default_nettype none

module srisc_regfile #(
  parameter int REG_COUNT = 8
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire  [srisc_pkg::RIDX_W-1:0]   ra_addr,
  input  wire  [srisc_pkg::RIDX_W-1:0]   rb_addr,
  output logic [srisc_pkg::WORD_W-1:0]   ra_data,
  output logic [srisc_pkg::WORD_W-1:0]   rb_data,
  input  srisc_pkg::rf_wr_t              wr
);
  import srisc_pkg::*;

  localparam int RW = $clog2(REG_COUNT);

  logic [WORD_W-1:0] regs [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [WORD_W-1:0] ra_raw;
  logic [WORD_W-1:0] rb_raw;
  logic              ra_v;
  logic              rb_v;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      regs[wr.addr[RW-1:0]] <= wr.data;
    end
    ra_raw <= regs[ra_addr[RW-1:0]];
    rb_raw <= regs[rb_addr[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ra_v  <= 1'b0;
      rb_v  <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr[RW-1:0]] <= 1'b1;
      end
      ra_v <= valid[ra_addr[RW-1:0]];
      rb_v <= valid[rb_addr[RW-1:0]];
    end
  end

  assign ra_data = ra_v ? ra_raw : '0;
  assign rb_data = rb_v ? rb_raw : '0;

endmodule

`default_nettype wire

[dv/sixteen_bit_risc_core_step_tb.sv]
// Testbench for sixteen_bit_risc_core_step: directed and random programs, with a
// cycle-free core model that predicts every result transaction. Depends on srisc_pkg
// and the core RTL only.
`timescale 1ns / 100ps

module sixteen_bit_risc_core_step_tb;
  import srisc_pkg::*;

  localparam int          MEM_WORDS  = 8192;
  localparam int          RAND_ITEMS = 900;
  localparam int          LONG_HOLD  = 300;
  localparam logic [1:0]  OP_NONE    = 2'd3;  // undefined item kind

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } core_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // load_addr[12:0], load_data[28:13], zero pad
  logic [1:0]  s_tuser = '0;   // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // pc_now, halted, reg_written, reg_index, reg_value, mem_written, mem_addr,
  // mem_data, read_data
  logic [79:0] m_tdata;

  sixteen_bit_risc_core_step dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // core model state
  logic [WORD_W-1:0] mem_img [0:MEM_WORDS-1];
  logic [WORD_W-1:0] regs [0:7];
  logic [ADDR_W-1:0] pc_q = '0;
  logic              halt_q = 1'b0;

  core_item_t items_to_send [$];
  res_t       results_due [$];
  core_item_t cur_item = '0;
  int         n_sent = 0;
  int         n_taken = 0;
  int         n_mismatch = 0;
  int         src_gap = 0;
  int         sink_gap = 0;
  int         hold_req = 0;
  int         hold_done = 0;
  logic       offer;
  logic       calm = 1'b0;

  initial begin
    for (int i = 0; i < MEM_WORDS; i++) mem_img[i] = '0;
    for (int i = 0; i < 8; i++) regs[i] = '0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // apply one item to the model and queue the result it must produce
  task automatic execute_item(input core_item_t it);
    res_t              r;
    logic [WORD_W-1:0] w, a, b, imm, val;
    logic [ADDR_W-1:0] nxt, ea;
    logic [2:0]        dst;
    logic              wr;
    r = '0;
    if (it.op == OP_LOAD) begin
      mem_img[it.addr] = it.data;
    end else if (it.op == OP_READ) begin
      r.read_data = mem_img[it.addr];
    end else if (it.op == OP_EXEC && !halt_q) begin
      w   = mem_img[pc_q];
      a   = regs[w[12:10]];
      b   = regs[w[9:7]];
      imm = {{9{w[6]}}, w[6:0]};
      nxt = pc_q + 13'd1;
      dst = w[9:7];
      wr  = 1'b1;
      val = '0;
      case (w[15:13])
        OPC_ALU: begin
          dst = w[6:4];
          case (w[3:0])
            FN_ADD: val = a + b;
            FN_SUB: val = a - b;
            FN_AND: val = a & b;
            FN_OR:  val = a | b;
            FN_SLT: val = {15'd0, a < b};
            FN_JR: begin
              wr  = 1'b0;
              nxt = a[ADDR_W-1:0];
            end
            default: wr = 1'b0;
          endcase
        end
        OPC_ADDI: val = a + imm;
        OPC_SLTI: val = {15'd0, a < imm};
        OPC_LW:   val = mem_img[a[ADDR_W-1:0] + imm[ADDR_W-1:0]];
        OPC_SW: begin
          wr            = 1'b0;
          ea            = a[ADDR_W-1:0] + imm[ADDR_W-1:0];
          r.mem_written = 1'b1;
          r.mem_addr    = ea;
          r.mem_data    = b;
          mem_img[ea]   = b;
        end
        OPC_JEQ: begin
          wr = 1'b0;
          if (a == b) nxt = pc_q + 13'd1 + imm[ADDR_W-1:0];
        end
        OPC_J: begin
          wr = 1'b0;
          if (w[ADDR_W-1:0] == pc_q) begin
            halt_q = 1'b1;
            nxt    = pc_q;
          end else begin
            nxt = w[ADDR_W-1:0];
          end
        end
        OPC_JAL: begin
          dst = LINK_REG;
          val = {3'b000, pc_q} + 16'd1;  // 8192 when linking from the top word
          nxt = w[ADDR_W-1:0];
        end
        default: wr = 1'b0;
      endcase
      if (wr && dst != 3'd0) begin
        regs[dst]     = val;
        r.reg_written = 1'b1;
        r.reg_index   = dst;
        r.reg_value   = val;
      end
      pc_q = nxt;
    end
    r.pc_now = pc_q;
    r.halted = halt_q;
    results_due = {results_due, r};
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (results_due.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing pending", got));
      return;
    end
    want = results_due.pop_front();
    cmp_field("pc_now", 16'(got.pc_now), 16'(want.pc_now));
    cmp_field("halted", 16'(got.halted), 16'(want.halted));
    cmp_field("reg_written", 16'(got.reg_written), 16'(want.reg_written));
    cmp_field("reg_index", 16'(got.reg_index), 16'(want.reg_index));
    cmp_field("reg_value", got.reg_value, want.reg_value);
    cmp_field("mem_written", 16'(got.mem_written), 16'(want.mem_written));
    cmp_field("mem_addr", 16'(got.mem_addr), 16'(want.mem_addr));
    cmp_field("mem_data", got.mem_data, want.mem_data);
    cmp_field("read_data", got.read_data, want.read_data);
  endtask

  // driver: one item held on the slave side until its transaction completes
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        execute_item(cur_item);
        n_taken++;
        offer = 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 10);
      end
      if (!offer) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (items_to_send.size() != 0) begin
          cur_item = items_to_send.pop_front();
          offer    = 1'b1;
        end
      end
      s_tvalid <= offer;
      s_tdata  <= {3'b000, cur_item.data, cur_item.addr};
      s_tuser  <= cur_item.op;
    end
  end

  // monitor: checks each result transaction, stalls the master side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(res_t'(m_tdata));
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        sink_gap  = LONG_HOLD;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                      input logic [WORD_W-1:0] data);
    core_item_t it;
    it.op   = op;
    it.addr = addr;
    it.data = data;
    items_to_send = {items_to_send, it};
    n_sent++;
  endtask

  function automatic logic [15:0] enc_ri(logic [2:0] opc, logic [2:0] ra, logic [2:0] rb,
                                         logic [6:0] imm);
    return {opc, ra, rb, imm};
  endfunction

  function automatic logic [15:0] enc_rrr(logic [2:0] ra, logic [2:0] rb, logic [2:0] rc,
                                          logic [3:0] fn);
    return {OPC_ALU, ra, rb, rc, fn};
  endfunction

  function automatic logic [15:0] enc_jmp(logic [2:0] opc, logic [ADDR_W-1:0] tgt);
    return {opc, tgt};
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 7))
      0:       return 13'd0;
      1:       return 13'h1FFF;
      default: return 13'($urandom);
    endcase
  endfunction

  // random instruction at 'at'; jumps mostly stay inside the program block
  function automatic logic [15:0] rand_insn(logic [ADDR_W-1:0] at, logic [ADDR_W-1:0] base,
                                            int span);
    logic [15:0]       w;
    logic [3:0]        fn;
    logic [ADDR_W-1:0] tgt;
    w         = 16'($urandom);
    w[15:13]  = 3'($urandom_range(0, 7));
    if (w[15:13] == OPC_ALU) begin
      case ($urandom_range(0, 6))
        0: fn = FN_ADD;
        1: fn = FN_SUB;
        2: fn = FN_AND;
        3: fn = FN_OR;
        4: fn = FN_SLT;
        5: fn = FN_JR;
        default: begin
          fn = 4'($urandom_range(5, 15));
          if (fn == FN_JR) fn = 4'd15;
        end
      endcase
      w[3:0] = fn;
    end else if (w[15:13] == OPC_J || w[15:13] == OPC_JAL) begin
      if ($urandom_range(0, 3) != 0) tgt = base + 13'($urandom_range(0, span - 1));
      else tgt = 13'($urandom);
      if (w[15:13] == OPC_J && tgt == at) tgt = at + 13'd1;
      w[ADDR_W-1:0] = tgt;
    end
    return w;
  endfunction

  initial begin : stimulus
    int                n_rand;
    int                phase;
    int                len;
    logic [ADDR_W-1:0] base;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: every opcode, wrap of addresses, r0 as target
    send(OP_READ, 13'h1FFF, 16'h0000);
    send(OP_LOAD, 13'd0,  enc_ri(OPC_ADDI, 3'd0, 3'd1, 7'h7F));   // r1 = -1
    send(OP_LOAD, 13'd1,  enc_ri(OPC_ADDI, 3'd0, 3'd2, 7'h3F));   // r2 = 63
    send(OP_LOAD, 13'd2,  enc_rrr(3'd1, 3'd2, 3'd3, FN_SLT));     // unsigned compare
    send(OP_LOAD, 13'd3,  enc_ri(OPC_SLTI, 3'd2, 3'd4, 7'h7F));   // imm sign-extends
    send(OP_LOAD, 13'd4,  enc_rrr(3'd2, 3'd1, 3'd5, FN_SUB));
    send(OP_LOAD, 13'd5,  enc_rrr(3'd1, 3'd2, 3'd0, FN_AND));     // r0 never written
    send(OP_LOAD, 13'd6,  enc_rrr(3'd1, 3'd2, 3'd6, FN_ADD));
    send(OP_LOAD, 13'd7,  enc_rrr(3'd1, 3'd2, 3'd6, 4'd15));      // unused funct
    send(OP_LOAD, 13'd8,  enc_ri(OPC_SW, 3'd0, 3'd2, 7'h7E));     // address wraps to 8190
    send(OP_LOAD, 13'd9,  enc_ri(OPC_LW, 3'd0, 3'd3, 7'h7E));
    send(OP_LOAD, 13'd10, enc_ri(OPC_JEQ, 3'd0, 3'd0, 7'd1));
    send(OP_LOAD, 13'd12, enc_jmp(OPC_JAL, 13'd20));
    send(OP_LOAD, 13'd20, enc_rrr(LINK_REG, 3'd0, 3'd0, FN_JR));
    send(OP_LOAD, 13'd13, enc_jmp(OPC_J, 13'h1FFF));
    send(OP_LOAD, 13'h1FFF, enc_jmp(OPC_JAL, 13'd16));            // links 8192
    repeat (15) send(OP_EXEC, 13'd0, 16'h0000);

    // random programs placed at the current pc, with data traffic around them
    n_rand = 0;
    phase  = 0;
    while (n_rand < RAND_ITEMS) begin
      while (n_taken != n_sent) @(posedge clk);
      if (phase % 20 == 19) begin
        while (results_due.size() != 0) @(posedge clk);
      end
      if (n_rand > RAND_ITEMS * 17 / 20) calm = 1'b1;
      if (phase == 12) hold_req++;
      base = pc_q;
      len  = $urandom_range(2, 12);
      repeat ($urandom_range(0, 2)) begin
        send(OP_LOAD, rand_addr(), rand_word());
        n_rand++;
      end
      // now and then run whatever memory already holds
      if ($urandom_range(0, 7) != 0) begin
        for (int i = 0; i < len; i++) begin
          send(OP_LOAD, base + 13'(i), rand_insn(base + 13'(i), base, len));
          n_rand++;
        end
      end
      repeat (len + $urandom_range(0, 4) + (phase == 12 ? 20 : 0)) begin
        send(OP_EXEC, rand_addr(), rand_word());
        n_rand++;
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) != 0) send(OP_READ, base + 13'($urandom_range(0, 15)),
                                              rand_word());
          else send(OP_READ, rand_addr(), rand_word());
          n_rand++;
        end
        if ($urandom_range(0, 29) == 0) send(OP_NONE, rand_addr(), rand_word());
      end
      phase++;
    end

    // halt on a jump to self, then memory traffic and steps while halted
    while (n_taken != n_sent) @(posedge clk);
    calm = 1'b1;
    base = pc_q;
    send(OP_LOAD, base, enc_jmp(OPC_J, base));
    send(OP_EXEC, 13'd0, 16'h0000);
    send(OP_EXEC, 13'h1FFF, 16'hFFFF);
    send(OP_LOAD, base + 13'd1, rand_word());
    send(OP_READ, base + 13'd1, 16'h0000);
    send(OP_NONE, 13'h1FFF, 16'hFFFF);
    send(OP_EXEC, 13'd0, 16'h0000);

    while (n_taken != n_sent) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sixteen_bit_risc_core_step.f]
design/srisc_pkg.sv
design/srisc_regfile.sv
design/sixteen_bit_risc_core_step.sv
dv/sixteen_bit_risc_core_step_tb.sv
